>>> hdl/jia_pkg.sv
// shared types and constants of the jvm integer alu
package jia_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned OpW      = 4;
  localparam int unsigned ShW      = 6;
  localparam int unsigned DivSteps = 64;

  localparam logic [OpW-1:0] OP_ADD  = 4'd0;
  localparam logic [OpW-1:0] OP_SUB  = 4'd1;
  localparam logic [OpW-1:0] OP_MUL  = 4'd2;
  localparam logic [OpW-1:0] OP_DIV  = 4'd3;
  localparam logic [OpW-1:0] OP_REM  = 4'd4;
  localparam logic [OpW-1:0] OP_NEG  = 4'd5;
  localparam logic [OpW-1:0] OP_SHL  = 4'd6;
  localparam logic [OpW-1:0] OP_SHR  = 4'd7;
  localparam logic [OpW-1:0] OP_USHR = 4'd8;
  localparam logic [OpW-1:0] OP_AND  = 4'd9;
  localparam logic [OpW-1:0] OP_OR   = 4'd10;
  localparam logic [OpW-1:0] OP_XOR  = 4'd11;

  localparam logic [4:0] INT_SH_MASK = 5'h1F;

  // one item in flight through the divide chain
  typedef struct packed {
    logic             valid;
    logic [OpW-1:0]   op;
    logic             lng;
    logic             na;
    logic             nb;
    logic             dz;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;   // dividend/quotient, or finished result for other ops
    logic [DataW-1:0] mb;
  } stage_t;

  function automatic logic [DataW-1:0] sext32(input logic [DataW-1:0] v);
    return {{HalfW{v[HalfW-1]}}, v[HalfW-1:0]};
  endfunction

  function automatic logic is_div(input logic [OpW-1:0] op);
    return (op == OP_DIV) || (op == OP_REM);
  endfunction

endpackage

>>> hdl/jia_if.sv
// request and result channel interfaces
interface jia_in_if;
  import jia_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          action;
  logic                    long_mode;
  logic signed [DataW-1:0] first_operand;
  logic signed [DataW-1:0] second_operand;
  modport source (output valid, action, long_mode, first_operand, second_operand,
                  input ready);
  modport sink (input valid, action, long_mode, first_operand, second_operand,
                output ready);
endinterface

interface jia_out_if;
  import jia_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result;
  logic                    divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink (input valid, result, divide_by_zero, output ready);
endinterface

>>> hdl/jia_front.sv
// decode, execute and multiply stages ahead of the divide chain
module jia_front
  import jia_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [OpW-1:0]   in_op,
  input  logic             in_lng,
  input  logic [DataW-1:0] in_a,
  input  logic [DataW-1:0] in_b,
  output stage_t           out_stage
);

  // stage 1: operand extension and divide magnitudes
  logic             v1_r;
  logic [OpW-1:0]   op1_r;
  logic             lng1_r, na1_r, nb1_r, dz1_r;
  logic [DataW-1:0] a1_r, b1_r, ma1_r, mb1_r;
  logic [ShW-1:0]   sh1_r;
  logic [DataW-1:0] a_nxt, b_nxt;

  assign a_nxt = in_lng ? in_a : sext32(in_a);
  assign b_nxt = in_lng ? in_b : sext32(in_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
    if (en) begin
      op1_r  <= in_op;
      lng1_r <= in_lng;
      a1_r   <= a_nxt;
      b1_r   <= b_nxt;
      sh1_r  <= in_lng ? b_nxt[ShW-1:0] : {1'b0, b_nxt[4:0] & INT_SH_MASK};
      na1_r  <= a_nxt[DataW-1];
      nb1_r  <= b_nxt[DataW-1];
      ma1_r  <= a_nxt[DataW-1] ? (~a_nxt + 64'd1) : a_nxt;
      mb1_r  <= b_nxt[DataW-1] ? (~b_nxt + 64'd1) : b_nxt;
      dz1_r  <= (b_nxt == '0);
    end
  end

  // stage 2: simple ops and multiply partial products
  logic             v2_r;
  logic [OpW-1:0]   op2_r;
  logic             lng2_r, na2_r, nb2_r, dz2_r;
  logic [DataW-1:0] ma2_r, mb2_r, sr2_r, p0_r;
  logic [HalfW-1:0] p1_r, p2_r;
  logic [DataW-1:0] sr_nxt;
  logic [HalfW-1:0] p1_full, p2_full;

  always_comb begin
    unique case (op1_r)
      OP_ADD:  sr_nxt = a1_r + b1_r;
      OP_SUB:  sr_nxt = a1_r - b1_r;
      OP_NEG:  sr_nxt = ~a1_r + 64'd1;
      OP_SHL:  sr_nxt = a1_r << sh1_r;
      OP_SHR:  sr_nxt = $unsigned($signed(a1_r) >>> sh1_r);
      OP_USHR: sr_nxt = lng1_r ? (a1_r >> sh1_r) : ({32'd0, a1_r[HalfW-1:0]} >> sh1_r);
      OP_AND:  sr_nxt = a1_r & b1_r;
      OP_OR:   sr_nxt = a1_r | b1_r;
      OP_XOR:  sr_nxt = a1_r ^ b1_r;
      default: sr_nxt = '0;
    endcase
  end

  // only the low halves of the cross products reach the 64-bit result
  assign p1_full = a1_r[HalfW-1:0] * b1_r[DataW-1:HalfW];
  assign p2_full = a1_r[DataW-1:HalfW] * b1_r[HalfW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      op2_r  <= op1_r;
      lng2_r <= lng1_r;
      na2_r  <= na1_r;
      nb2_r  <= nb1_r;
      dz2_r  <= dz1_r;
      ma2_r  <= ma1_r;
      mb2_r  <= mb1_r;
      sr2_r  <= sr_nxt;
      p0_r   <= a1_r[HalfW-1:0] * b1_r[HalfW-1:0];
      p1_r   <= p1_full;
      p2_r   <= p2_full;
    end
  end

  // stage 3: product sum and result select
  stage_t           s3_r;
  logic [DataW-1:0] mr, res;
  logic [HalfW-1:0] cross_sum;

  assign cross_sum = p1_r + p2_r;
  assign mr        = p0_r + {cross_sum, 32'd0};
  always_comb begin
    res = (op2_r == OP_MUL) ? mr : sr2_r;
    if (!lng2_r) begin
      res = sext32(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r.valid <= v2_r;
    end
    if (en) begin
      s3_r.op  <= op2_r;
      s3_r.lng <= lng2_r;
      s3_r.na  <= na2_r;
      s3_r.nb  <= nb2_r;
      s3_r.dz  <= dz2_r;
      s3_r.rem <= '0;
      s3_r.quo <= is_div(op2_r) ? ma2_r : res;
      s3_r.mb  <= mb2_r;
    end
  end

  assign out_stage = s3_r;

endmodule

>>> hdl/jia_div_stage.sv
// one restoring divide step, one quotient bit per stage
module jia_div_stage
  import jia_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t d,
  output stage_t q
);

  stage_t         q_r, q_nxt;
  logic [DataW:0] shifted, diff;

  assign shifted = {d.rem, d.quo[DataW-1]};
  assign diff    = shifted - {1'b0, d.mb};

  always_comb begin
    q_nxt = d;
    if (is_div(d.op)) begin
      if (!diff[DataW]) begin
        q_nxt.rem = diff[DataW-1:0];
        q_nxt.quo = {d.quo[DataW-2:0], 1'b1};
      end else begin
        q_nxt.rem = shifted[DataW-1:0];
        q_nxt.quo = {d.quo[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      q_r.op  <= q_nxt.op;
      q_r.lng <= q_nxt.lng;
      q_r.na  <= q_nxt.na;
      q_r.nb  <= q_nxt.nb;
      q_r.dz  <= q_nxt.dz;
      q_r.rem <= q_nxt.rem;
      q_r.quo <= q_nxt.quo;
      q_r.mb  <= q_nxt.mb;
    end
  end

  assign q = q_r;

endmodule

>>> hdl/jvm_integer_alu.sv
// jvm integer alu: int and long arithmetic and logic bytecodes
//
// in_req carries one request per valid/ready handshake: an operation code,
// the int/long mode and the two operands popped from the operand stack.
// out_res returns exactly one result per request, in request order, with the
// divide_by_zero flag for div and rem by zero (result then zero).
// Every operation passes through three front stages (decode,
// execute with multiply partial products, product sum), 64 divide stages
// that each retire one quotient bit, and the output register. Operations
// other than div and rem ride the divide stages unchanged so order is kept.
// Throughput is one request per cycle while the receiver does not stall;
// the 64-step restoring divide chain sets the depth.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so in_req.ready follows out_res.ready; bubbles are
// carried as cleared valid bits. While the receiver stalls with a result
// waiting, everything holds and nothing is lost or repeated.
// Synchronous reset clears all valid bits; payload registers are not reset.
module jvm_integer_alu
  import jia_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  jia_in_if.sink     in_req,
  jia_out_if.source  out_res
);

  logic             en;
  logic             out_vld_r, out_dz_r;
  logic [DataW-1:0] out_res_r, fin;
  stage_t           pipe [0:DivSteps];

  assign en = !out_vld_r || out_res.ready;
  assign in_req.ready = en;

  jia_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_req.valid),
    .in_op     (in_req.action),
    .in_lng    (in_req.long_mode),
    .in_a      (in_req.first_operand),
    .in_b      (in_req.second_operand),
    .out_stage (pipe[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    jia_div_stage u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (pipe[i]),
      .q     (pipe[i+1])
    );
  end

  // sign fix-up of quotient and remainder, zero result on divide by zero
  always_comb begin
    fin = pipe[DivSteps].quo;
    if (is_div(pipe[DivSteps].op)) begin
      if (pipe[DivSteps].dz) begin
        fin = '0;
      end else if (pipe[DivSteps].op == OP_DIV) begin
        fin = (pipe[DivSteps].na ^ pipe[DivSteps].nb) ?
              (~pipe[DivSteps].quo + 64'd1) : pipe[DivSteps].quo;
      end else begin
        fin = pipe[DivSteps].na ? (~pipe[DivSteps].rem + 64'd1) : pipe[DivSteps].rem;
      end
      if (!pipe[DivSteps].lng) begin
        fin = sext32(fin);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= pipe[DivSteps].valid;
    end
    if (en) begin
      out_res_r <= fin;
      out_dz_r  <= is_div(pipe[DivSteps].op) && pipe[DivSteps].dz;
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.result         = out_res_r;
  assign out_res.divide_by_zero = out_dz_r;

endmodule

>>> hdl/jia_chk.sv
// port-level checks for the jvm integer alu
module jia_chk
  import jia_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] out_result,
  input logic             out_dz
);

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow result side");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_result == '0)
    else $error("divide by zero with non-zero result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_dz))
    else $error("stalled result changed");

endmodule

bind jvm_integer_alu jia_chk u_jia_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_result (out_res.result),
  .out_dz     (out_res.divide_by_zero)
);
